### hw/rtl/skf_pkg.sv
// Package for the scalar Kalman filter: widths, microcode word layout and
// saturation helpers. No dependencies.
package skf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 66;  // signed 33x33 product
  localparam int DEN_SPAN      = 64;  // divisor width is DEN_SPAN - FRAC_BITS
  localparam int CFG_IDX_W     = 3;
  localparam int STEP_W        = 5;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AX,    // A * x
    MUL_AA,    // A * A
    MUL_HX1,   // H * x1
    MUL_AAP,   // AA * p
    MUL_P1H,   // p1 * H
    MUL_NH,    // n * H
    MUL_GI,    // g * innovation
    MUL_GH,    // g * H
    MUL_OP1    // (1 - gH) * p1
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_X1,
    WB_AA,
    WB_INNOV,
    WB_P1,
    WB_N,
    WB_D,
    WB_G,
    WB_X,
    WB_ONEM,
    WB_P
  } wb_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,  // stay until a measurement arrives
    HOLD_DIV,    // stay while the divider runs
    HOLD_OUT     // stay while the result register is full and stalled
  } hold_t;

  typedef struct packed {
    mul_op_t             mul_op;
    wb_t                 wb;
    logic                take_in;
    logic                div_go;
    logic                emit;
    hold_t               hold_on;
    logic                jump;
    logic [STEP_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic out_block;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_op:  MUL_NONE,
    wb:      WB_NONE,
    take_in: 1'b0,
    div_go:  1'b0,
    emit:    1'b0,
    hold_on: HOLD_NONE,
    jump:    1'b0,
    target:  '0
  };

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (&v[PROD_W-1:31] || ~|v[PROD_W-1:31]) begin
      r = v[31:0];
    end else if (v[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [30:0] sat_cov(input logic signed [PROD_W-1:0] v);
    logic [30:0] r;
    if (v[PROD_W-1]) begin
      r = '0;
    end else if (|v[PROD_W-2:31]) begin
      r = 31'h7FFF_FFFF;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter, top level: microcode sequencer plus datapath.
// Depends on skf_pkg, skf_seq, skf_dp (skf_div).
//
// Usage:
//   Measurement channel (meas_valid/meas_stall/measurement): one signed
//   fixed-point sample per transaction. Result channel (res_valid/res_stall/
//   estimate/kalman_gain): one transaction per measurement, in order.
//   Configuration: cfg_write with cfg_index/cfg_data, write only while idle.
//   The bit-serial divider, which produces 32+FRAC_BITS quotient bits for the
//   gain, dominates the processing of a measurement; the rest is microcode
//   steps on one shared multiplier.
//   The result sits in an output register, so a stalled result only holds the
//   sequencer at its last step; the next measurement can still be taken while
//   a result waits. One item is processed at a time.
//   Reset (rst, synchronous) restores the configuration registers to defaults,
//   sets the estimate to 0 and the covariance to 1.0, and empties the output.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  meas_valid,
  output logic                  meas_stall,
  input  logic signed [31:0]    measurement,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic signed [31:0]    estimate,
  output logic signed [31:0]    kalman_gain
);

  ctrl_t ctrl;
  stat_t stat;

  skf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .stat       (stat),
    .ctrl       (ctrl),
    .meas_stall (meas_stall)
  );

  skf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctrl        (ctrl),
    .meas_valid  (meas_valid),
    .measurement (measurement),
    .res_stall   (res_stall),
    .stat        (stat),
    .res_valid   (res_valid),
    .estimate    (estimate),
    .kalman_gain (kalman_gain)
  );

endmodule

### hw/rtl/skf_div.sv
// Restoring divider, one quotient bit per cycle, with signed result saturated
// to 32 bits and zero on a zero divisor. Depends on skf_pkg.
module skf_div import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic signed [31:0]                    num,
  input  logic signed [DEN_SPAN-FRAC_BITS-1:0]  den,
  output logic                                  busy,
  output logic signed [31:0]                    quo
);

  localparam int D_W   = DEN_SPAN - FRAC_BITS;
  localparam int N_W   = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   qr;     // dividend shifts out, quotient shifts in
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic             neg;
  logic             zero;
  logic [CNT_W-1:0] cnt;

  logic [31:0]      nmag;
  logic [D_W-1:0]   dmag;
  logic [D_W:0]     rem_sh;
  logic             ge;

  assign nmag   = num[31] ? 32'(-num) : 32'(num);
  assign dmag   = den[D_W-1] ? D_W'(-den) : D_W'(den);
  assign rem_sh = {rem, qr[N_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zero <= 1'b1;
    end else if (go) begin
      zero <= (den == '0);
      busy <= (den != '0);
      cnt  <= CNT_W'(N_W - 1);
      qr   <= N_W'(nmag) << FRAC_BITS;
      rem  <= '0;
      dvs  <= dmag;
      neg  <= num[31] ^ den[D_W-1];
    end else if (busy) begin
      rem <= ge ? D_W'(rem_sh - {1'b0, dvs}) : rem_sh[D_W-1:0];
      qr  <= {qr[N_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (zero) begin
      quo = '0;
    end else if (neg) begin
      quo = (qr > N_W'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-qr[31:0]);
    end else begin
      quo = (qr > N_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(qr[31:0]);
    end
  end

endmodule

### hw/rtl/skf_dp.sv
// Datapath: configuration registers, filter state, one shared multiplier with
// writeback logic, the divider and the result register. Depends on skf_pkg, skf_div.
module skf_dp import skf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  ctrl_t                 ctrl,
  input  logic                  meas_valid,
  input  logic signed [31:0]    measurement,
  input  logic                  res_stall,
  output stat_t                 stat,
  output logic                  res_valid,
  output logic signed [31:0]    estimate,
  output logic signed [31:0]    kalman_gain
);

  localparam int D_W = DEN_SPAN - FRAC_BITS;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic [31:0] ONE32   = 32'(ONE_L);
  localparam logic [30:0] Q_RESET = 31'((2 * ONE_L + 50) / 100);
  localparam logic [30:0] R_RESET = 31'((13 * ONE_L + 50) / 100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRANS,
    CFG_OBS,
    CFG_QNOISE,
    CFG_RNOISE,
    CFG_INIT_EST,
    CFG_INIT_COV
  } cfg_idx_t;

  logic signed [31:0]       trans_gain;
  logic signed [31:0]       obs_gain;
  logic [30:0]              process_noise;
  logic [30:0]              meas_noise;

  logic signed [31:0]       x;
  logic [30:0]              p;
  logic signed [31:0]       z;
  logic signed [31:0]       x1;
  logic signed [31:0]       aa;
  logic signed [32:0]       innov;
  logic [30:0]              p1;
  logic signed [31:0]       n;
  logic signed [D_W-1:0]    d;
  logic signed [31:0]       g;
  logic signed [32:0]       onem;
  logic signed [PROD_W-1:0] prod;

  logic signed [32:0]       opa;
  logic signed [32:0]       opb;
  logic signed [PROD_W-1:0] sh;
  logic signed [31:0]       sh_sat;
  logic                     div_busy;
  logic signed [31:0]       div_quo;
  logic                     out_block;

  assign sh        = prod >>> FRAC_BITS;
  assign sh_sat    = sat32(sh);
  assign out_block = res_valid & res_stall;
  assign stat      = '{div_busy: div_busy, out_block: out_block};

  // Writes to the init indices are ignored and reset loads the state with fixed
  // defaults, so written init values never reach the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_gain    <= signed'(ONE32);
      obs_gain      <= signed'(ONE32);
      process_noise <= Q_RESET;
      meas_noise    <= R_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRANS:    trans_gain    <= cfg_data;
        CFG_OBS:      obs_gain      <= cfg_data;
        CFG_QNOISE:   process_noise <= cfg_data[30:0];
        CFG_RNOISE:   meas_noise    <= cfg_data[30:0];
        CFG_INIT_EST: ;
        CFG_INIT_COV: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.mul_op)
      MUL_AX:  begin opa = 33'(trans_gain); opb = 33'(x);          end
      MUL_AA:  begin opa = 33'(trans_gain); opb = 33'(trans_gain); end
      MUL_HX1: begin opa = 33'(obs_gain);   opb = 33'(x1);         end
      MUL_AAP: begin opa = 33'(aa);         opb = {2'b00, p};      end
      MUL_P1H: begin opa = {2'b00, p1};     opb = 33'(obs_gain);   end
      MUL_NH:  begin opa = 33'(n);          opb = 33'(obs_gain);   end
      MUL_GI:  begin opa = 33'(g);          opb = innov;           end
      MUL_GH:  begin opa = 33'(g);          opb = 33'(obs_gain);   end
      MUL_OP1: begin opa = onem;            opb = {2'b00, p1};     end
      default: begin opa = '0;              opb = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NONE) begin
      prod <= opa * opb;
    end
    if (ctrl.take_in && meas_valid) begin
      z <= measurement;
    end
    case (ctrl.wb)
      WB_X1:    x1    <= sh_sat;
      WB_AA:    aa    <= sh_sat;
      WB_INNOV: innov <= 33'(z) - 33'(sh_sat);
      WB_P1:    p1    <= sat_cov(sh + PROD_W'(signed'({1'b0, process_noise})));
      WB_N:     n     <= sh_sat;
      WB_D:     d     <= D_W'(sh + PROD_W'(signed'({1'b0, meas_noise})));
      WB_G:     g     <= div_quo;
      WB_ONEM:  onem  <= 33'(signed'({1'b0, ONE32})) - 33'(sh_sat);
      default: ;
    endcase
  end

  // filter state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      x         <= '0;
      p         <= ONE32[30:0];
      res_valid <= 1'b0;
    end else begin
      if (ctrl.wb == WB_X) begin
        x <= sat32(sh + PROD_W'(x1));
      end
      if (ctrl.wb == WB_P) begin
        p <= sat_cov(sh);
      end
      if (ctrl.emit && !out_block) begin
        res_valid   <= 1'b1;
        estimate    <= x;
        kalman_gain <= g;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  skf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (ctrl.div_go),
    .num  (n),
    .den  (d),
    .busy (div_busy),
    .quo  (div_quo)
  );

endmodule

### hw/rtl/skf_seq.sv
// Microcode sequencer: step counter, control store and hold/jump logic.
// Depends on skf_pkg.
module skf_seq import skf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  meas_valid,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  meas_stall
);

  localparam logic [STEP_W-1:0] ST_IDLE = '0;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              hold;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t w;
    w = CTRL_NOP;
    case (s)
      5'd0:  begin w.take_in = 1'b1; w.hold_on = HOLD_INPUT; end
      5'd1:  begin w.mul_op = MUL_AX; end
      5'd2:  begin w.wb = WB_X1;    w.mul_op = MUL_AA;  end
      5'd3:  begin w.wb = WB_AA;    w.mul_op = MUL_HX1; end
      5'd4:  begin w.wb = WB_INNOV; w.mul_op = MUL_AAP; end
      5'd5:  begin w.wb = WB_P1; end
      5'd6:  begin w.mul_op = MUL_P1H; end
      5'd7:  begin w.wb = WB_N; end
      5'd8:  begin w.mul_op = MUL_NH; end
      5'd9:  begin w.wb = WB_D; end
      5'd10: begin w.div_go = 1'b1; end
      5'd11: begin w.hold_on = HOLD_DIV; end
      5'd12: begin w.wb = WB_G; end
      5'd13: begin w.mul_op = MUL_GI; end
      5'd14: begin w.wb = WB_X;     w.mul_op = MUL_GH; end
      5'd15: begin w.wb = WB_ONEM; end
      5'd16: begin w.mul_op = MUL_OP1; end
      5'd17: begin
        w.wb      = WB_P;
        w.emit    = 1'b1;
        w.hold_on = HOLD_OUT;
        w.jump    = 1'b1;
        w.target  = ST_IDLE;
      end
      default: begin w.jump = 1'b1; w.target = ST_IDLE; end
    endcase
    return w;
  endfunction

  assign ctrl       = ucode(step);
  assign meas_stall = !ctrl.take_in;

  always_comb begin
    case (ctrl.hold_on)
      HOLD_INPUT: hold = !meas_valid;
      HOLD_DIV:   hold = stat.div_busy;
      HOLD_OUT:   hold = stat.out_block;
      default:    hold = 1'b0;
    endcase
    if (hold) begin
      step_next = step;
    end else if (ctrl.jump) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

### hw/rtl/skf_chk.sv
// Port-level checker for scalar_kalman_filter and its bind statement.
// Depends on scalar_kalman_filter.
module skf_chk (
  input logic        clk,
  input logic        rst,
  input logic        meas_valid,
  input logic        meas_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [31:0] estimate,
  input logic [31:0] kalman_gain
);

  logic meas_take;
  assign meas_take = meas_valid && !meas_stall;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(estimate) && $stable(kalman_gain))
    else $error("result changed while stalled");

  // leaving reset: output empty and ready for a measurement
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !meas_stall)
    else $error("bad state after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    meas_take |=> meas_stall)
    else $error("measurement taken while busy");

  // a fresh result cannot appear right after a measurement is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    meas_take |=> !$rose(res_valid))
    else $error("result too early");

endmodule

bind scalar_kalman_filter skf_chk u_skf_chk (
  .clk         (clk),
  .rst         (rst),
  .meas_valid  (meas_valid),
  .meas_stall  (meas_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .estimate    (estimate),
  .kalman_gain (kalman_gain)
);

### verif/scalar_kalman_filter_tb.sv
// Self-checking testbench for scalar_kalman_filter: directed table, then random
// register phases and measurement streams, checked against a fixed-point predictor.
// Depends on skf_pkg and the scalar_kalman_filter RTL.
module scalar_kalman_filter_tb;

  localparam int FRAC            = skf_pkg::FRAC_BITS_DEF;
  localparam int IDX_W           = skf_pkg::CFG_IDX_W;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int CFG_SETTLE      = 4;
  localparam int TAIL_CYCLES     = FRAC + 60;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 93;
  localparam int NUM_ROWS        = 34;
  localparam int MAX_PRINTS      = 50;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;
  localparam longint ONE_Q       = 64'sd1 <<< FRAC;

  typedef enum logic [IDX_W-1:0] {
    REG_TRANS, REG_OBS, REG_QNOISE, REG_RNOISE,
    REG_INIT_X, REG_INIT_P, REG_SPARE6, REG_SPARE7
  } reg_idx_t;

  typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;
  typedef enum int {PH_TRACK, PH_WILD, PH_EDGE} phase_kind_t;
  typedef enum int {RX_READY, RX_RANDOM, RX_SPARSE, RX_HOLD} stall_mode_t;

  typedef struct packed {
    logic signed [31:0] est;
    logic signed [31:0] gain;
  } kf_out_t;

  typedef struct packed {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [31:0]        val;
    logic               typed;
    logic signed [31:0] want_est;
    logic signed [31:0] want_gain;
  } row_t;

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    cfg_write   = 1'b0;
  logic [IDX_W-1:0]        cfg_index   = REG_TRANS;
  logic [31:0]             cfg_data    = 32'h0;
  logic                    meas_valid  = 1'b0;
  logic                    meas_stall;
  logic signed [31:0]      measurement = 32'sh0;
  logic                    res_valid;
  logic                    res_stall   = 1'b0;
  logic signed [31:0]      estimate;
  logic signed [31:0]      kalman_gain;

  // predictor copy of the registers and filter state (values after reset)
  longint coef_a  = ONE_Q;
  longint coef_h  = ONE_Q;
  longint noise_q = 64'sd1311;
  longint noise_r = 64'sd8520;
  longint init_x  = 64'sd0;    // init values are not used by the predictor
  longint init_p  = ONE_Q;
  longint x_state = 64'sd0;
  longint p_state = ONE_Q;

  kf_out_t pending_estimates [$];
  kf_out_t head;
  int      err_count   = 0;
  int      cycle_count = 0;
  int      burst_left  = 0;
  int      walk        = 0;
  bit      valid_on    = 1'b0;

  // columns: kind, register, value or measurement, typed, estimate, gain
  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_MEAS, REG_TRANS,  32'h0000_0000, 1'b1, 32'sd0, 32'sd58127},  // defaults
    '{ROW_CFG,  REG_OBS,    32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_RNOISE, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h7FFF_FFFF, 1'b1, 32'sd0, 32'sd0},      // zero denominator
    '{ROW_MEAS, REG_TRANS,  32'h8000_0000, 1'b1, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_OBS,    32'h0001_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_RNOISE, 32'd8520,      1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h0000_0001, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_TRANS,  32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},      // estimate overflow
    '{ROW_CFG,  REG_QNOISE, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},      // bit 31 dropped
    '{ROW_MEAS, REG_TRANS,  32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h1234_5678, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_TRANS,  32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_OBS,    32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_RNOISE, 32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h8000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_TRANS,  32'h0001_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_OBS,    32'h0000_0003, 1'b0, 32'sd0, 32'sd0},      // tiny H: gain*H > 1
    '{ROW_CFG,  REG_QNOISE, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_RNOISE, 32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h4000_0000, 1'b0, 32'sd0, 32'sd0},      // covariance clamps at 0
    '{ROW_MEAS, REG_TRANS,  32'h0001_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'hC000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_INIT_X, 32'h8000_0000, 1'b0, 32'sd0, 32'sd0},      // no effect on the state
    '{ROW_CFG,  REG_INIT_P, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_CFG,  REG_SPARE6, 32'hDEAD_BEEF, 1'b0, 32'sd0, 32'sd0},      // unmapped index
    '{ROW_CFG,  REG_SPARE7, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h0000_0000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'h5555_AAAA, 1'b0, 32'sd0, 32'sd0},
    '{ROW_MEAS, REG_TRANS,  32'hAAAA_5555, 1'b0, 32'sd0, 32'sd0}
  };

  scalar_kalman_filter #(.FRAC_BITS(FRAC)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .measurement(measurement),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .estimate   (estimate),
    .kalman_gain(kalman_gain)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint clamp_cov(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < 0) return 64'sd0;
    return v;
  endfunction

  // exact product, floor of the scaled result
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic kf_out_t kalman_step(input logic [31:0] z);
    longint  x1, aa, p1, n, d, g, innov, onem;
    kf_out_t r;
    x1 = sat_s32(qmul(coef_a, x_state));
    aa = sat_s32(qmul(coef_a, coef_a));
    p1 = clamp_cov(qmul(aa, p_state) + noise_q);
    n = sat_s32(qmul(p1, coef_h));
    d = qmul(n, coef_h) + noise_r;
    g = (d == 0) ? 64'sd0 : sat_s32((n <<< FRAC) / d);
    innov = longint'(signed'(z)) - sat_s32(qmul(coef_h, x1));
    x_state = sat_s32(x1 + qmul(g, innov));
    onem = ONE_Q - sat_s32(qmul(g, coef_h));
    p_state = clamp_cov(qmul(onem, p1));
    r.est = x_state[31:0];
    r.gain = g[31:0];
    return r;
  endfunction

  function automatic void load_reg(input reg_idx_t idx, input logic [31:0] data);
    case (idx)
      REG_TRANS:  coef_a = longint'(signed'(data));
      REG_OBS:    coef_h = longint'(signed'(data));
      REG_QNOISE: noise_q = longint'(data[30:0]);
      REG_RNOISE: noise_r = longint'(data[30:0]);
      REG_INIT_X: init_x = longint'(signed'(data));
      REG_INIT_P: init_p = longint'(data[30:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // tracking phases mostly follow a slow random walk with noise; the rest is wide
  function automatic logic [31:0] next_meas(input phase_kind_t kind);
    if (kind == PH_TRACK && $urandom_range(0, 15) != 0) begin
      walk += int'($urandom_range(0, 8192)) - 4096;
      return 32'(walk + int'($urandom_range(0, 65535)) - 32768);
    end
    case ($urandom_range(0, 3))
      0: return edge_word();
      1: return 32'(int'($urandom_range(0, 131071)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
  endtask

  task automatic drop_valid();
    if (valid_on) begin
      meas_valid <= 1'b0;
      valid_on = 1'b0;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_estimates.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    drop_valid();
    wait_drained();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    load_reg(idx, data);
  endtask

  // bursts of back-to-back transactions, then a gap or a full drain
  task automatic item_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_valid();
      if ($urandom_range(0, 9) == 0) wait_drained();
      else repeat ($urandom_range(1, 70)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic feed(input logic [31:0] z, input logic typed, input kf_out_t want);
    kf_out_t pred;
    meas_valid  <= 1'b1;
    measurement <= z;
    valid_on = 1'b1;
    do @(posedge clk); while (meas_stall);
    pred = kalman_step(z);
    pending_estimates.push_back(typed ? want : pred);
    item_gap();
  endtask

  task automatic program_phase(input phase_kind_t kind);
    logic [31:0] a_word, h_word, q_word, r_word, x0_word, p0_word;
    case (kind)
      PH_TRACK: begin
        a_word = 32'(65536 + int'($urandom_range(0, 13108)) - 6554);
        h_word = $urandom_range(32768, 131072);
        if ($urandom_range(0, 3) == 0) h_word = -h_word;
        q_word = $urandom_range(0, 8192);
        r_word = $urandom_range(0, 1 << 18);
        x0_word = $urandom();
        p0_word = $urandom();
      end
      PH_WILD: begin
        a_word = $urandom();
        h_word = $urandom();
        q_word = $urandom();
        r_word = $urandom();
        x0_word = $urandom();
        p0_word = $urandom();
      end
      default: begin
        a_word = edge_word();
        h_word = edge_word();
        q_word = edge_word();
        r_word = edge_word();
        x0_word = edge_word();
        p0_word = edge_word();
      end
    endcase
    write_reg(REG_TRANS, a_word);
    write_reg(REG_OBS, h_word);
    write_reg(REG_QNOISE, q_word);
    write_reg(REG_RNOISE, r_word);
    write_reg(REG_INIT_X, x0_word);
    write_reg(REG_INIT_P, p0_word);
    if ($urandom_range(0, 1) == 0) write_reg(REG_SPARE6, $urandom());
    else write_reg(REG_SPARE7, $urandom());
  endtask

  // receiver: segments of ready, random, sparse or solid stall
  initial begin
    stall_mode_t mode;
    int          seg;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      seg = (mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(1, 64);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          RX_READY:  res_stall <= 1'b0;
          RX_RANDOM: res_stall <= $urandom_range(0, 1);
          RX_SPARSE: res_stall <= ($urandom_range(0, 3) == 0);
          default:   res_stall <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (!rst && res_valid && !res_stall) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("result with no transaction pending", estimate, 32'h0);
      end else begin
        head = pending_estimates.pop_front();
        if (estimate !== head.est) report_mismatch("estimate", estimate, head.est);
        if (kalman_gain !== head.gain) report_mismatch("kalman_gain", kalman_gain, head.gain);
      end
    end
  end

  initial begin
    kf_out_t     row_want;
    kf_out_t     no_want;
    phase_kind_t kind;
    no_want = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        row_want.est  = directed_rows[i].want_est;
        row_want.gain = directed_rows[i].want_gain;
        feed(directed_rows[i].val, directed_rows[i].typed, row_want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        1: kind = PH_WILD;
        3: kind = PH_EDGE;
        default: kind = PH_TRACK;
      endcase
      program_phase(kind);
      walk = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      repeat (ITEMS_PER_PHASE) feed(next_meas(kind), 1'b0, no_want);
    end

    drop_valid();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_estimates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/skf_pkg.sv
hw/rtl/skf_div.sv
hw/rtl/skf_dp.sv
hw/rtl/skf_seq.sv
hw/rtl/scalar_kalman_filter.sv
hw/rtl/skf_chk.sv
verif/scalar_kalman_filter_tb.sv
